// File: rtl/core/cht_pkg.sv
`timescale 1ns / 1ps

package cht_pkg;

   localparam int STATUS_WIDTH = 3;
   localparam int HANDLE_WIDTH = 11;
   localparam int LEN_WIDTH    = 11;
   localparam logic [LEN_WIDTH-1:0] LEN_RESET = 11'd1024;

   typedef enum logic [1:0] {
      KIND_SEARCH = 2'd0,
      KIND_INSERT = 2'd1,
      KIND_DELETE = 2'd2,
      KIND_CLEAR  = 2'd3
   } kind_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      ST_FOUND     = 3'd0,
      ST_INSERTED  = 3'd1,
      ST_NOT_FOUND = 3'd2,
      ST_DELETED   = 3'd3,
      ST_POOL_FULL = 3'd4,
      ST_INVALID   = 3'd5,
      ST_CLEARED   = 3'd6
   } status_type;

   // classification made by the front part
   typedef struct packed {
      kind_type kind;
      logic     key_zero;
   } cht_item_type;

endpackage

// File: rtl/core/cht_front.sv
`timescale 1ns / 1ps

module cht_front #(
   parameter int KEY_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_kind,
   input  logic [KEY_WIDTH-1:0]  req_key,
   output logic                  q_valid,
   output cht_pkg::cht_item_type q_item,
   output logic [KEY_WIDTH-1:0]  q_key,
   input  logic                  q_pop
);
   import cht_pkg::*;

   // two-entry queue toward the back part
   cht_item_type         item_ff [2];
   logic [KEY_WIDTH-1:0] key_ff [2];
   logic                 wr_ptr_ff, wr_ptr_in;
   logic                 rd_ptr_ff, rd_ptr_in;
   logic [1:0]           count_ff, count_in;
   logic                 push;
   cht_item_type         new_item;

   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != 2'd0);
   assign q_item    = item_ff[rd_ptr_ff];
   assign q_key     = key_ff[rd_ptr_ff];

   always_comb begin
      new_item.kind     = kind_type'(req_kind);
      new_item.key_zero = (req_key == '0);
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ q_pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         item_ff[wr_ptr_ff] <= new_item;
         key_ff[wr_ptr_ff]  <= req_key;
      end
   end

endmodule

// File: rtl/core/cht_back.sv
`timescale 1ns / 1ps

module cht_back #(
   parameter int TOP_BUCKETS  = 1024,
   parameter int POOL_ENTRIES = 256,
   parameter int KEY_WIDTH    = 32,
   parameter int BW           = 11
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              q_valid,
   input  cht_pkg::cht_item_type             q_item,
   input  logic [KEY_WIDTH-1:0]              q_key,
   output logic                              q_pop,
   input  logic [BW-1:0]                     eff_len,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [cht_pkg::STATUS_WIDTH-1:0]  rsp_status,
   output logic [cht_pkg::HANDLE_WIDTH-1:0]  rsp_handle
);
   import cht_pkg::*;

   localparam int AW = (TOP_BUCKETS > 1) ? $clog2(TOP_BUCKETS) : 1;
   localparam int PW = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
   localparam int LW = $clog2(POOL_ENTRIES + 1);
   localparam int CW = $clog2(KEY_WIDTH);
   localparam logic [AW-1:0] LAST_BKT  = AW'(TOP_BUCKETS - 1);
   localparam logic [LW-1:0] POOL_N    = LW'(POOL_ENTRIES);
   localparam logic [LW-1:0] POOL_LAST = LW'(POOL_ENTRIES - 1);
   localparam logic [CW-1:0] DIV_LAST  = CW'(KEY_WIDTH - 1);
   localparam logic [31:0]   TOP_BASE  = 32'(TOP_BUCKETS);

   typedef enum logic [9:0] {
      S_CLEAR    = 10'b0000000001,
      S_IDLE     = 10'b0000000010,
      S_DIV      = 10'b0000000100,
      S_TOP_RD   = 10'b0000001000,
      S_TOP_CHK  = 10'b0000010000,
      S_POOL_CHK = 10'b0000100000,
      S_MISS     = 10'b0001000000,
      S_ALLOC    = 10'b0010000000,
      S_LINK     = 10'b0100000000,
      S_SUCC     = 10'b1000000000
   } state_type;

   // memories
   logic [KEY_WIDTH-1:0] top_key_mem  [TOP_BUCKETS];
   logic [LW-1:0]        top_link_mem [TOP_BUCKETS];
   logic [KEY_WIDTH-1:0] pool_key_mem  [POOL_ENTRIES];
   logic [LW-1:0]        pool_link_mem [POOL_ENTRIES];
   logic [PW-1:0]        stack_mem [POOL_ENTRIES];

   logic                 top_rd, top_key_we, top_link_we;
   logic [AW-1:0]        top_addr;
   logic [KEY_WIDTH-1:0] top_key_wd, top_key_q;
   logic [LW-1:0]        top_link_wd, top_link_q;
   logic                 pool_rd, pool_key_we, pool_link_we;
   logic [PW-1:0]        pool_rd_addr, pool_wr_addr;
   logic [KEY_WIDTH-1:0] pool_key_wd, pool_key_q;
   logic [LW-1:0]        pool_link_wd, pool_link_q;
   logic                 stack_rd, stack_we;
   logic [PW-1:0]        stack_rd_addr, stack_wr_addr, stack_wd, stack_q;

   state_type            state_ff, state_in;
   kind_type             kind_ff, kind_in;
   logic [KEY_WIDTH-1:0] key_ff, key_in;
   logic [KEY_WIDTH-1:0] dsh_ff, dsh_in;
   logic [BW-1:0]        rem_ff, rem_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [AW-1:0]        bkt_ff, bkt_in;
   logic [KEY_WIDTH-1:0] top_key_ff, top_key_in;
   logic [PW-1:0]        cur_ff, cur_in;
   logic [PW-1:0]        prev_ff, prev_in;
   logic                 has_prev_ff, has_prev_in;
   logic [AW-1:0]        sweep_ff, sweep_in;
   logic                 clr_reply_ff, clr_reply_in;
   logic [LW-1:0]        free_cnt_ff, free_cnt_in;
   logic [LW-1:0]        low_ff, low_in;
   logic [LW-1:0]        pos_ff, pos_in;
   logic                 fresh_ff, fresh_in;
   logic [PW-1:0]        alloc_ff, alloc_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STATUS_WIDTH-1:0] rsp_status_ff, rsp_status_in;
   logic [HANDLE_WIDTH-1:0] rsp_handle_ff, rsp_handle_in;

   logic [BW:0]          div_sh;
   logic [LW-1:0]        pos_dec;
   logic [PW-1:0]        alloc_p;
   logic [LW-1:0]        link_chk;

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_handle = rsp_handle_ff;

   function automatic logic [HANDLE_WIDTH-1:0] pool_handle(input logic [PW-1:0] p);
      logic [31:0] sum;
      sum = TOP_BASE + 32'(p);
      return sum[HANDLE_WIDTH-1:0];
   endfunction

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      key_in        = key_ff;
      dsh_in        = dsh_ff;
      rem_in        = rem_ff;
      cnt_in        = cnt_ff;
      bkt_in        = bkt_ff;
      top_key_in    = top_key_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      has_prev_in   = has_prev_ff;
      sweep_in      = sweep_ff;
      clr_reply_in  = clr_reply_ff;
      free_cnt_in   = free_cnt_ff;
      low_in        = low_ff;
      pos_in        = pos_ff;
      fresh_in      = fresh_ff;
      alloc_in      = alloc_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_handle_in = rsp_handle_ff;
      q_pop         = 1'b0;

      top_rd        = 1'b0;
      top_key_we    = 1'b0;
      top_link_we   = 1'b0;
      top_addr      = bkt_ff;
      top_key_wd    = top_key_ff;
      top_link_wd   = '0;
      pool_rd       = 1'b0;
      pool_rd_addr  = '0;
      pool_key_we   = 1'b0;
      pool_link_we  = 1'b0;
      pool_wr_addr  = '0;
      pool_key_wd   = key_ff;
      pool_link_wd  = '0;
      stack_rd      = 1'b0;
      stack_rd_addr = pos_ff[PW-1:0];
      stack_we      = 1'b0;
      stack_wr_addr = free_cnt_ff[PW-1:0];
      stack_wd      = cur_ff;

      div_sh   = {rem_ff, dsh_ff[KEY_WIDTH-1]};
      pos_dec  = free_cnt_ff - LW'(1);
      link_chk = '0;
      alloc_p  = fresh_ff ? PW'(POOL_LAST - pos_ff) : stack_q;

      case (state_ff)
         S_CLEAR: begin
            top_addr    = sweep_ff;
            top_key_we  = 1'b1;
            top_link_we = 1'b1;
            top_key_wd  = '0;
            if (sweep_ff == LAST_BKT) begin
               state_in = S_IDLE;
               if (clr_reply_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_CLEARED;
                  rsp_handle_in = '0;
               end
            end else begin
               sweep_in = sweep_ff + AW'(1);
            end
         end
         S_IDLE: begin
            if (q_valid && (!rsp_valid_ff || !rsp_stall)) begin
               q_pop   = 1'b1;
               kind_in = q_item.kind;
               key_in  = q_key;
               if (q_item.kind == KIND_CLEAR) begin
                  state_in     = S_CLEAR;
                  sweep_in     = '0;
                  clr_reply_in = 1'b1;
                  free_cnt_in  = POOL_N;
                  low_in       = POOL_N;
               end else if (q_item.key_zero) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_INVALID;
                  rsp_handle_in = '0;
               end else begin
                  state_in = S_DIV;
                  dsh_in   = q_key;
                  rem_in   = '0;
                  cnt_in   = '0;
               end
            end
         end
         S_DIV: begin
            // restoring remainder, one key bit a cycle
            if (div_sh >= {1'b0, eff_len}) begin
               rem_in = BW'(div_sh - {1'b0, eff_len});
            end else begin
               rem_in = div_sh[BW-1:0];
            end
            dsh_in = {dsh_ff[KEY_WIDTH-2:0], 1'b0};
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == DIV_LAST) begin
               state_in = S_TOP_RD;
            end
         end
         S_TOP_RD: begin
            bkt_in   = rem_ff[AW-1:0];
            top_addr = rem_ff[AW-1:0];
            top_rd   = 1'b1;
            state_in = S_TOP_CHK;
         end
         S_TOP_CHK: begin
            top_key_in  = top_key_q;
            has_prev_in = 1'b0;
            link_chk    = top_link_q;
            if (top_key_q == key_ff) begin
               if (kind_ff == KIND_DELETE) begin
                  if (link_chk != '0 && link_chk <= POOL_N) begin
                     pool_rd      = 1'b1;
                     pool_rd_addr = PW'(link_chk - LW'(1));
                     cur_in       = PW'(link_chk - LW'(1));
                     state_in     = S_SUCC;
                  end else begin
                     top_key_we    = 1'b1;
                     top_link_we   = 1'b1;
                     top_key_wd    = '0;
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_DELETED;
                     rsp_handle_in = HANDLE_WIDTH'(bkt_ff);
                     state_in      = S_IDLE;
                  end
               end else begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_FOUND;
                  rsp_handle_in = HANDLE_WIDTH'(bkt_ff);
                  state_in      = S_IDLE;
               end
            end else if (top_key_q == '0) begin
               state_in = S_IDLE;
               rsp_valid_in = 1'b1;
               if (kind_ff == KIND_INSERT) begin
                  top_key_we    = 1'b1;
                  top_link_we   = 1'b1;
                  top_key_wd    = key_ff;
                  rsp_status_in = ST_INSERTED;
                  rsp_handle_in = HANDLE_WIDTH'(bkt_ff);
               end else begin
                  rsp_status_in = ST_NOT_FOUND;
                  rsp_handle_in = '0;
               end
            end else if (link_chk != '0 && link_chk <= POOL_N) begin
               pool_rd      = 1'b1;
               pool_rd_addr = PW'(link_chk - LW'(1));
               cur_in       = PW'(link_chk - LW'(1));
               state_in     = S_POOL_CHK;
            end else begin
               state_in = S_MISS;
            end
         end
         S_POOL_CHK: begin
            link_chk = pool_link_q;
            if (pool_key_q == key_ff) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               if (kind_ff == KIND_DELETE) begin
                  // unlink, then hand the entry back to the free stack
                  if (has_prev_ff) begin
                     pool_link_we = 1'b1;
                     pool_wr_addr = prev_ff;
                     pool_link_wd = pool_link_q;
                  end else begin
                     top_link_we = 1'b1;
                     top_link_wd = pool_link_q;
                  end
                  if (free_cnt_ff < POOL_N) begin
                     stack_we    = 1'b1;
                     free_cnt_in = free_cnt_ff + LW'(1);
                  end
                  rsp_status_in = ST_DELETED;
               end else begin
                  rsp_status_in = ST_FOUND;
               end
               rsp_handle_in = pool_handle(cur_ff);
            end else begin
               prev_in     = cur_ff;
               has_prev_in = 1'b1;
               if (link_chk != '0 && link_chk <= POOL_N) begin
                  pool_rd      = 1'b1;
                  pool_rd_addr = PW'(link_chk - LW'(1));
                  cur_in       = PW'(link_chk - LW'(1));
               end else begin
                  state_in = S_MISS;
               end
            end
         end
         S_MISS: begin
            if (kind_ff == KIND_INSERT && free_cnt_ff != '0) begin
               // pop the free stack; slots below the low mark still hold reset order
               stack_rd      = 1'b1;
               stack_rd_addr = pos_dec[PW-1:0];
               pos_in        = pos_dec;
               fresh_in      = (pos_dec < low_ff);
               free_cnt_in   = pos_dec;
               if (pos_dec < low_ff) begin
                  low_in = pos_dec;
               end
               state_in = S_ALLOC;
            end else begin
               state_in      = S_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_handle_in = '0;
               rsp_status_in = (kind_ff == KIND_INSERT) ? ST_POOL_FULL : ST_NOT_FOUND;
            end
         end
         S_ALLOC: begin
            pool_key_we  = 1'b1;
            pool_link_we = 1'b1;
            pool_wr_addr = alloc_p;
            pool_key_wd  = key_ff;
            pool_link_wd = '0;
            alloc_in     = alloc_p;
            state_in     = S_LINK;
         end
         S_LINK: begin
            if (has_prev_ff) begin
               pool_link_we = 1'b1;
               pool_wr_addr = prev_ff;
               pool_link_wd = LW'(alloc_ff) + LW'(1);
            end else begin
               top_link_we = 1'b1;
               top_link_wd = LW'(alloc_ff) + LW'(1);
            end
            rsp_valid_in  = 1'b1;
            rsp_status_in = ST_INSERTED;
            rsp_handle_in = pool_handle(alloc_ff);
            state_in      = S_IDLE;
         end
         S_SUCC: begin
            // successor moves up into the top entry
            top_key_we  = 1'b1;
            top_link_we = 1'b1;
            top_key_wd  = pool_key_q;
            top_link_wd = pool_link_q;
            if (free_cnt_ff < POOL_N) begin
               stack_we    = 1'b1;
               free_cnt_in = free_cnt_ff + LW'(1);
            end
            rsp_valid_in  = 1'b1;
            rsp_status_in = ST_DELETED;
            rsp_handle_in = HANDLE_WIDTH'(bkt_ff);
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         sweep_ff     <= '0;
         clr_reply_ff <= 1'b0;
         free_cnt_ff  <= POOL_N;
         low_ff       <= POOL_N;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         clr_reply_ff <= clr_reply_in;
         free_cnt_ff  <= free_cnt_in;
         low_ff       <= low_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      key_ff        <= key_in;
      dsh_ff        <= dsh_in;
      rem_ff        <= rem_in;
      cnt_ff        <= cnt_in;
      bkt_ff        <= bkt_in;
      top_key_ff    <= top_key_in;
      cur_ff        <= cur_in;
      prev_ff       <= prev_in;
      has_prev_ff   <= has_prev_in;
      pos_ff        <= pos_in;
      fresh_ff      <= fresh_in;
      alloc_ff      <= alloc_in;
      rsp_status_ff <= rsp_status_in;
      rsp_handle_ff <= rsp_handle_in;
   end

   always_ff @(posedge clock) begin
      if (top_key_we) begin
         top_key_mem[top_addr] <= top_key_wd;
      end
      if (top_link_we) begin
         top_link_mem[top_addr] <= top_link_wd;
      end
      if (top_rd) begin
         top_key_q  <= top_key_mem[top_addr];
         top_link_q <= top_link_mem[top_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (pool_key_we) begin
         pool_key_mem[pool_wr_addr] <= pool_key_wd;
      end
      if (pool_link_we) begin
         pool_link_mem[pool_wr_addr] <= pool_link_wd;
      end
      if (pool_rd) begin
         pool_key_q  <= pool_key_mem[pool_rd_addr];
         pool_link_q <= pool_link_mem[pool_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (stack_we) begin
         stack_mem[stack_wr_addr] <= stack_wd;
      end
      if (stack_rd) begin
         stack_q <= stack_mem[stack_rd_addr];
      end
   end

endmodule

// File: rtl/core/chained_hash_table.sv
`timescale 1ns / 1ps
// flow: bucket modulo (one key bit a cycle), top table read and check; a top hit or a free top
//   entry answers there, otherwise the chain walk reads one overflow entry per step until a hit,
//   a miss or pool full at the chain end; a pool insert allocates then links; a top delete with a
//   successor pulls it up. The back end handles one transaction at a time.
// clear sweeps one top entry a cycle; an invalid key is answered from idle without the modulo
// reset: synchronous, clears the top table before work starts
module chained_hash_table #(
   parameter int TOP_BUCKETS  = 1024,
   parameter int POOL_ENTRIES = 256,
   parameter int KEY_WIDTH    = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [1:0]                       req_kind,
   input  logic [KEY_WIDTH-1:0]             req_key,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [cht_pkg::STATUS_WIDTH-1:0] rsp_status,
   output logic [cht_pkg::HANDLE_WIDTH-1:0] rsp_handle,
   input  logic                             csr_wr_en,
   input  logic [cht_pkg::LEN_WIDTH-1:0]    csr_wr_data
);
   import cht_pkg::*;

   // width of the effective table length, holds TOP_BUCKETS itself
   localparam int BW = $clog2(TOP_BUCKETS + 1);

   logic [LEN_WIDTH-1:0] len_ff, len_in;
   logic [BW-1:0]        eff_len;
   logic                 q_valid;
   cht_item_type         q_item;
   logic [KEY_WIDTH-1:0] q_key;
   logic                 q_pop;

   // table length register
   always_comb begin
      len_in = csr_wr_en ? csr_wr_data : len_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= LEN_RESET;
      end else begin
         len_ff <= len_in;
      end
   end

   // zero acts as one, anything above the bucket count is clamped
   always_comb begin
      if (len_ff == '0) begin
         eff_len = BW'(1);
      end else if (32'(len_ff) > 32'(TOP_BUCKETS)) begin
         eff_len = BW'(TOP_BUCKETS);
      end else begin
         eff_len = BW'(len_ff);
      end
   end

   // front: takes transactions, flags zero keys, queues them
   cht_front #(
      .KEY_WIDTH (KEY_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_kind  (req_kind),
      .req_key   (req_key),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_key     (q_key),
      .q_pop     (q_pop)
   );

   // back: modulo, chain walk, table updates, response register
   cht_back #(
      .TOP_BUCKETS  (TOP_BUCKETS),
      .POOL_ENTRIES (POOL_ENTRIES),
      .KEY_WIDTH    (KEY_WIDTH),
      .BW           (BW)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_key      (q_key),
      .q_pop      (q_pop),
      .eff_len    (eff_len),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_status (rsp_status),
      .rsp_handle (rsp_handle)
   );

endmodule

// File: test/chained_hash_table_test.sv
`timescale 1ns / 1ps

module chained_hash_table_test;
   import cht_pkg::*;

   localparam int TOP_N  = 1024;
   localparam int POOL_N = 256;

   typedef struct {
      kind_type    kind;
      logic [31:0] key;
   } table_op_type;

   typedef struct {
      status_type              status;
      logic [HANDLE_WIDTH-1:0] handle;
   } table_answer_type;

   logic                    clock = 0;
   logic                    reset = 1;
   logic                    req_valid = 0;
   logic                    req_stall;
   logic [1:0]              req_kind = KIND_SEARCH;
   logic [31:0]             req_key = 0;
   logic                    rsp_valid;
   logic                    rsp_stall = 0;
   logic [STATUS_WIDTH-1:0] rsp_status;
   logic [HANDLE_WIDTH-1:0] rsp_handle;
   logic                    csr_wr_en = 0;
   logic [LEN_WIDTH-1:0]    csr_wr_data = 0;

   // shadow copy of the table contents
   logic [31:0]          model_top_keys  [TOP_N];
   logic [8:0]           model_top_links [TOP_N];
   logic [31:0]          model_pool_keys [POOL_N];
   logic [8:0]           model_pool_links[POOL_N];
   logic [7:0]           model_free_stack[POOL_N];
   int unsigned          model_free_count;
   logic [LEN_WIDTH-1:0] model_length;

   table_op_type     pending_ops[$];
   table_answer_type expected_answers[$];

   int  error_count   = 0;
   bit  quiet         = 0;   // no idling on either side in the last part
   bit  req_taken     = 0;
   int  gap_left      = 0;
   int  stall_left    = 0;
   int  hold_left     = 0;
   int  hold_requests = 0;
   int  holds_done    = 0;

   chained_hash_table uut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_kind   (req_kind),
      .req_key    (req_key),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_status (rsp_status),
      .rsp_handle (rsp_handle),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always #4 clock = ~clock;

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $time, msg);
      error_count++;
   endtask

   // empty table, every pool entry free with index 0 on top of the stack
   function automatic void clear_model();
      for (int i = 0; i < TOP_N; i++) begin
         model_top_keys[i]  = 0;
         model_top_links[i] = 0;
      end
      for (int i = 0; i < POOL_N; i++) begin
         model_pool_keys[i]  = 0;
         model_pool_links[i] = 0;
         model_free_stack[i] = 8'(POOL_N - 1 - i);
      end
      model_free_count = POOL_N;
   endfunction

   function automatic int unsigned effective_length(input logic [LEN_WIDTH-1:0] len);
      if (len == 0) return 1;
      if (len > TOP_N) return TOP_N;
      return len;
   endfunction

   function automatic void free_pool_entry(input int unsigned p);
      if (model_free_count < POOL_N) begin
         model_free_stack[model_free_count] = 8'(p);
         model_free_count++;
      end
   endfunction

   // applies one transaction to the shadow table and gives the expected answer
   function automatic table_answer_type apply_operation(input table_op_type op);
      table_answer_type ans;
      int unsigned      bucket, link, hit, prev, steps, s;
      bit               at_top, in_pool, has_prev;
      ans.status = ST_NOT_FOUND;
      ans.handle = 0;
      at_top = 0; in_pool = 0; has_prev = 0;
      hit = 0; prev = 0; steps = 0;
      if (op.kind == KIND_CLEAR) begin
         clear_model();
         ans.status = ST_CLEARED;
         return ans;
      end
      if (op.key == 0) begin
         ans.status = ST_INVALID;
         return ans;
      end
      bucket = op.key % effective_length(model_length);
      // walk the bucket chain
      if (model_top_keys[bucket] == op.key) at_top = 1;
      else if (model_top_keys[bucket] != 0) begin
         link = model_top_links[bucket];
         while (link != 0 && link <= POOL_N && steps < POOL_N) begin
            if (model_pool_keys[link-1] == op.key) begin
               in_pool = 1;
               hit = link - 1;
               break;
            end
            prev = link - 1;
            has_prev = 1;
            link = model_pool_links[link-1];
            steps++;
         end
      end
      if (op.kind == KIND_SEARCH || (op.kind == KIND_INSERT && (at_top || in_pool))) begin
         if (at_top) begin
            ans.status = ST_FOUND;
            ans.handle = HANDLE_WIDTH'(bucket);
         end else if (in_pool) begin
            ans.status = ST_FOUND;
            ans.handle = HANDLE_WIDTH'(TOP_N + hit);
         end
         return ans;
      end
      if (op.kind == KIND_INSERT) begin
         if (model_top_keys[bucket] == 0) begin
            model_top_keys[bucket]  = op.key;
            model_top_links[bucket] = 0;
            ans.status = ST_INSERTED;
            ans.handle = HANDLE_WIDTH'(bucket);
            return ans;
         end
         if (model_free_count == 0) begin
            ans.status = ST_POOL_FULL;
            return ans;
         end
         model_free_count--;
         s = model_free_stack[model_free_count];
         model_pool_keys[s]  = op.key;
         model_pool_links[s] = 0;
         if (has_prev) model_pool_links[prev] = 9'(s + 1);
         else model_top_links[bucket] = 9'(s + 1);
         ans.status = ST_INSERTED;
         ans.handle = HANDLE_WIDTH'(TOP_N + s);
         return ans;
      end
      // delete: a top entry pulls its successor up
      if (at_top) begin
         link = model_top_links[bucket];
         if (link != 0 && link <= POOL_N) begin
            model_top_keys[bucket]  = model_pool_keys[link-1];
            model_top_links[bucket] = model_pool_links[link-1];
            free_pool_entry(link - 1);
         end else begin
            model_top_keys[bucket]  = 0;
            model_top_links[bucket] = 0;
         end
         ans.status = ST_DELETED;
         ans.handle = HANDLE_WIDTH'(bucket);
      end else if (in_pool) begin
         if (has_prev) model_pool_links[prev] = model_pool_links[hit];
         else model_top_links[bucket] = model_pool_links[hit];
         free_pool_entry(hit);
         ans.status = ST_DELETED;
         ans.handle = HANDLE_WIDTH'(TOP_N + hit);
      end
      return ans;
   endfunction

   // request driver, changes at the falling edge
   always @(negedge clock) begin : request_driver
      table_op_type op;
      if (reset) begin
         req_valid <= 0;
      end else if (!req_valid || req_taken) begin
         if (gap_left > 0) begin
            gap_left  <= gap_left - 1;
            req_valid <= 0;
         end else if (pending_ops.size() > 0) begin
            op = pending_ops.pop_front();
            req_valid <= 1;
            req_kind  <= op.kind;
            req_key   <= op.key;
            if (!quiet && $urandom_range(0, 9) == 0) gap_left <= $urandom_range(1, 3);
         end else begin
            req_valid <= 0;
         end
      end
   end

   // result receiver: short random stalls plus long hold-offs on request
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1;
         hold_left <= hold_left - 1;
      end else if (holds_done != hold_requests) begin
         holds_done <= holds_done + 1;
         hold_left  <= 300;
         rsp_stall  <= 1;
      end else if (stall_left > 0) begin
         rsp_stall  <= 1;
         stall_left <= stall_left - 1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         rsp_stall  <= 1;
         stall_left <= $urandom_range(0, 2);
      end else begin
         rsp_stall <= 0;
      end
   end

   // monitor: predicts on accepted requests, checks accepted results
   always @(posedge clock) begin : monitor
      table_answer_type want;
      table_op_type     op;
      req_taken <= !reset && req_valid && !req_stall;
      if (!reset) begin
         if (csr_wr_en) model_length = csr_wr_data;
         if (rsp_valid && !rsp_stall) begin
            if (expected_answers.size() == 0) begin
               report_mismatch($sformatf("unexpected result status %0d handle %0d",
                                         rsp_status, rsp_handle));
            end else begin
               want = expected_answers.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_status, want.status));
               if (rsp_handle !== want.handle)
                  report_mismatch($sformatf("handle %0d, expected %0d",
                                            rsp_handle, want.handle));
            end
         end
         if (req_valid && !req_stall) begin
            op.kind = kind_type'(req_kind);
            op.key  = req_key;
            expected_answers.push_back(apply_operation(op));
         end
      end
   end

   task automatic add_op(input kind_type kind, input logic [31:0] key);
      table_op_type op;
      op.kind = kind;
      op.key  = key;
      pending_ops.push_back(op);
   endtask

   // sender holds off until every transaction has come back
   task automatic wait_drained();
      do begin
         @(posedge clock);
         #1;
      end while (pending_ops.size() != 0 || req_valid || expected_answers.size() != 0);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_length(input logic [LEN_WIDTH-1:0] len);
      wait_drained();
      @(negedge clock);
      csr_wr_en   <= 1;
      csr_wr_data <= len;
      @(negedge clock);
      csr_wr_en <= 0;
   endtask

   // keys mostly crowd a few buckets so chains form and get hit
   function automatic logic [31:0] pick_key(input int unsigned eff);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 4) return 0;
      if (r < 14) return $urandom;
      if (r < 16) return 32'hFFFF_FFFF;
      return $urandom_range(0, (eff > 8) ? 7 : eff - 1) + eff * $urandom_range(0, 9);
   endfunction

   task automatic random_phase(input int count);
      int unsigned eff, r;
      kind_type    kind;
      eff = effective_length(model_length);
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         if (r < 35) kind = KIND_SEARCH;
         else if (r < 72) kind = KIND_INSERT;
         else if (r < 98) kind = KIND_DELETE;
         else kind = KIND_CLEAR;
         add_op(kind, pick_key(eff));
      end
   endtask

   initial begin
      clear_model();
      model_length = LEN_RESET;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: zero key, top and pool inserts, duplicates, deletes, clear
      add_op(KIND_INSERT, 0);
      add_op(KIND_SEARCH, 0);
      add_op(KIND_DELETE, 0);
      add_op(KIND_INSERT, 5);
      add_op(KIND_INSERT, 1029);
      add_op(KIND_INSERT, 2053);
      add_op(KIND_INSERT, 5);
      add_op(KIND_SEARCH, 2053);
      add_op(KIND_SEARCH, 3077);
      add_op(KIND_DELETE, 5);
      add_op(KIND_SEARCH, 1029);
      add_op(KIND_DELETE, 2053);
      add_op(KIND_INSERT, 32'hFFFF_FFFF);
      add_op(KIND_SEARCH, 32'hFFFF_FFFF);
      add_op(KIND_DELETE, 777);
      add_op(KIND_CLEAR, 0);
      add_op(KIND_SEARCH, 1029);
      wait_drained();

      // receiver holds off long while the sender keeps offering
      hold_requests++;
      random_phase(260);

      // length zero acts as one
      write_length(0);
      random_phase(200);

      // one busy bucket until the pool runs out
      write_length(2);
      add_op(KIND_CLEAR, 0);
      for (int k = 1; k <= 262; k++) add_op(KIND_INSERT, 2 * k);
      add_op(KIND_SEARCH, 2 * 262);
      add_op(KIND_DELETE, 2 * 100);
      add_op(KIND_INSERT, 2 * 262);
      random_phase(100);
      add_op(KIND_CLEAR, 0);

      // oversize length acts as the full table; entries stay under the old divisor
      write_length(11'd2047);
      random_phase(260);
      write_length(1);
      random_phase(200);
      write_length(37);
      hold_requests++;
      random_phase(260);
      write_length(3);
      random_phase(200);

      // last part runs without idling
      write_length(1024);
      quiet = 1;
      random_phase(200);

      wait_drained();
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #40000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// File: chained_hash_table.f
rtl/core/cht_pkg.sv
rtl/core/cht_front.sv
rtl/core/cht_back.sv
rtl/core/chained_hash_table.sv
test/chained_hash_table_test.sv
